@@ sv/assert_macros.svh @@
// Assertion shorthands; clk and arst_n must be in scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EBRF_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EBRF_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ebrf_pkg.sv @@
package ebrf_pkg;

	typedef enum logic [2:0] {
		PH_FETCH = 3'b001,
		PH_OPER  = 3'b010,
		PH_LONG  = 3'b100
	} phase_t;

	localparam logic [3:0] GRP_LDN  = 4'h0;
	localparam logic [3:0] GRP_INC  = 4'h1;
	localparam logic [3:0] GRP_DEC  = 4'h2;
	localparam logic [3:0] GRP_BR   = 4'h3;
	localparam logic [3:0] GRP_LDA  = 4'h4;
	localparam logic [3:0] GRP_STR  = 4'h5;
	localparam logic [3:0] GRP_IO   = 4'h6;
	localparam logic [3:0] GRP_MISC = 4'h7;
	localparam logic [3:0] GRP_GLO  = 4'h8;
	localparam logic [3:0] GRP_GHI  = 4'h9;
	localparam logic [3:0] GRP_PLO  = 4'hA;
	localparam logic [3:0] GRP_PHI  = 4'hB;
	localparam logic [3:0] GRP_LBR  = 4'hC;
	localparam logic [3:0] GRP_SEP  = 4'hD;
	localparam logic [3:0] GRP_SEX  = 4'hE;
	localparam logic [3:0] GRP_ALU  = 4'hF;

	localparam logic [3:0] N_IRX  = 4'h0;
	localparam logic [3:0] N_RET  = 4'h0;
	localparam logic [3:0] N_DIS  = 4'h1;
	localparam logic [3:0] N_LDXA = 4'h2;
	localparam logic [3:0] N_STXD = 4'h3;
	localparam logic [3:0] N_SHRC = 4'h6;
	localparam logic [3:0] N_SAV  = 4'h8;
	localparam logic [3:0] N_MARK = 4'h9;
	localparam logic [3:0] N_REQ  = 4'hA;
	localparam logic [3:0] N_SEQ  = 4'hB;
	localparam logic [3:0] N_SHLC = 4'hE;
	localparam logic [3:0] N_SHR  = 4'h6;
	localparam logic [3:0] N_SHL  = 4'hE;

	localparam logic [2:0] ALU_LD  = 3'd0;
	localparam logic [2:0] ALU_OR  = 3'd1;
	localparam logic [2:0] ALU_AND = 3'd2;
	localparam logic [2:0] ALU_XOR = 3'd3;
	localparam logic [2:0] ALU_ADD = 3'd4;
	localparam logic [2:0] ALU_SD  = 3'd5;
	localparam logic [2:0] ALU_SM  = 3'd7;

	typedef struct packed {
		logic [7:0] d;
		logic       df;
		logic       d_we;
		logic       df_we;
	} alu_res_t;

endpackage

@@ sv/ebrf_alu.sv @@
module ebrf_alu (
	input  logic [2:0]         op,
	input  logic [7:0]         m,
	input  logic [7:0]         d,
	input  logic               df,
	input  logic               chained,
	output ebrf_pkg::alu_res_t res
);

	logic       cin_add;
	logic       cin_sub;
	logic [8:0] sum;

	assign cin_add = chained ? df : 1'b0;
	assign cin_sub = chained ? df : 1'b1;

	always_comb begin
		sum       = 9'd0;
		res.d     = d;
		res.df    = df;
		res.d_we  = 1'b1;
		res.df_we = 1'b0;
		unique case (op)
			ebrf_pkg::ALU_LD:  res.d = m;
			ebrf_pkg::ALU_OR:  res.d = d | m;
			ebrf_pkg::ALU_AND: res.d = d & m;
			ebrf_pkg::ALU_XOR: res.d = d ^ m;
			ebrf_pkg::ALU_ADD: sum = {1'b0, m} + {1'b0, d} + {8'd0, cin_add};
			ebrf_pkg::ALU_SD:  sum = {1'b0, m} + {1'b0, ~d} + {8'd0, cin_sub};
			ebrf_pkg::ALU_SM:  sum = {1'b0, d} + {1'b0, ~m} + {8'd0, cin_sub};
			default:           res.d_we = 1'b0;
		endcase
		if (op == ebrf_pkg::ALU_ADD || op == ebrf_pkg::ALU_SD || op == ebrf_pkg::ALU_SM) begin
			res.d     = sum[7:0];
			res.df    = sum[8];
			res.df_we = 1'b1;
		end
	end

endmodule

@@ sv/eight_bit_register_file_cpu_core.sv @@
// Eight-bit core with sixteen 16-bit registers; one transfer per bus cycle.
// rsp channel (rsp_valid/rsp_stall): read_data answers the previous request,
//   ef_lines carries EF1..EF4 (bit 0 is EF1). read_data is ignored after a write.
// req channel (req_valid/req_stall): the next bus request (bus_addr, bus_write,
//   write_data) with q_level, ie_level and instr_done.
// Every rsp transfer gives exactly one req transfer.
// A taken response is held in the input register, then its request is registered.
// Throughput: one transfer per cycle unless stalled; the decode, ALU add and
//   register update sit in one stage between the input register and the request register.
// Reset: registers, D, DF, Q, IE, P and X clear; a fetch from address 0 is
//   taken as pending, so the first response must carry the byte at address 0.
//   No request is shown until that response arrives.
// Stall: a stalled request holds; one more response is taken into the input
//   register, after which rsp_stall rises until the request is transferred.
`include "assert_macros.svh"

module eight_bit_register_file_cpu_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rsp_valid,
	output logic        rsp_stall,
	input  logic [7:0]  read_data,
	input  logic [3:0]  ef_lines,
	output logic        req_valid,
	input  logic        req_stall,
	output logic [15:0] bus_addr,
	output logic        bus_write,
	output logic [7:0]  write_data,
	output logic        q_level,
	output logic        ie_level,
	output logic        instr_done
);

	logic                 valid_s1;
	logic [7:0]           rd_s1;
	logic [3:0]           ef_s1;
	logic                 fire;
	logic                 rsp_take;

	logic [15:0]          rf_q [16];
	logic [15:0]          rf_n [16];
	logic [3:0]           p_q, p_n, x_q, x_n;
	logic [7:0]           d_q, d_n, op_q, op_n, hi_q, hi_n;
	logic                 df_q, df_n, qf_q, qf_n, ie_q, ie_n;
	ebrf_pkg::phase_t     phase_q, phase_n;

	logic                 done;
	logic                 wr;
	logic [3:0]           rsel;
	logic                 short_flag, long_flag;
	ebrf_pkg::alu_res_t   alu_res;

	logic                 req_valid_q;
	logic [15:0]          addr_q;
	logic                 wr_q;
	logic [7:0]           wdata_q;
	logic                 qf_out_q, ie_out_q, done_q;

	function automatic logic needs_mem(input logic [7:0] op);
		logic [3:0] n;
		n = op[3:0];
		case (op[7:4])
			ebrf_pkg::GRP_LDN, ebrf_pkg::GRP_BR, ebrf_pkg::GRP_LDA, ebrf_pkg::GRP_STR:
				needs_mem = 1'b1;
			ebrf_pkg::GRP_MISC:
				needs_mem = !(n inside {ebrf_pkg::N_SHRC, ebrf_pkg::N_SAV, ebrf_pkg::N_MARK,
					ebrf_pkg::N_REQ, ebrf_pkg::N_SEQ, ebrf_pkg::N_SHLC});
			ebrf_pkg::GRP_LBR:
				needs_mem = !op[2];
			ebrf_pkg::GRP_ALU:
				needs_mem = !(n inside {ebrf_pkg::N_SHR, ebrf_pkg::N_SHL});
			default:
				needs_mem = 1'b0;
		endcase
	endfunction

	assign fire      = valid_s1 && (!req_valid_q || !req_stall);
	assign rsp_stall = valid_s1 && !(!req_valid_q || !req_stall);
	assign rsp_take  = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rsp_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			rd_s1 <= read_data;
			ef_s1 <= ef_lines;
		end
	end

	always_comb begin
		unique case (op_q[2:0])
			3'd0:    short_flag = 1'b1;
			3'd1:    short_flag = qf_q;
			3'd2:    short_flag = (d_q == 8'd0);
			3'd3:    short_flag = df_q;
			default: short_flag = ef_s1[op_q[1:0]];
		endcase
		unique case (op_q[1:0])
			2'd0:    long_flag = 1'b1;
			2'd1:    long_flag = qf_q;
			2'd2:    long_flag = (d_q == 8'd0);
			default: long_flag = df_q;
		endcase
	end

	ebrf_alu u_alu (
		.op      (op_q[2:0]),
		.m       (rd_s1),
		.d       (d_q),
		.df      (df_q),
		.chained (op_q[7:4] == ebrf_pkg::GRP_MISC),
		.res     (alu_res)
	);

	always_comb begin
		rf_n    = rf_q;
		p_n     = p_q;
		x_n     = x_q;
		d_n     = d_q;
		df_n    = df_q;
		qf_n    = qf_q;
		ie_n    = ie_q;
		op_n    = op_q;
		hi_n    = hi_q;
		phase_n = ebrf_pkg::PH_FETCH;
		done    = 1'b0;
		unique case (phase_q)
			ebrf_pkg::PH_OPER: begin
				if (op_q[7:4] == ebrf_pkg::GRP_LBR) begin
					hi_n       = rd_s1;
					rf_n[p_q]  = rf_q[p_q] + 16'd1;
					phase_n    = ebrf_pkg::PH_LONG;
				end else begin
					done = 1'b1;
					case (op_q[7:4])
						ebrf_pkg::GRP_LDN: d_n = rd_s1;
						ebrf_pkg::GRP_LDA: begin
							d_n              = rd_s1;
							rf_n[op_q[3:0]]  = rf_q[op_q[3:0]] + 16'd1;
						end
						ebrf_pkg::GRP_BR: begin
							rf_n[p_q] = (short_flag ^ op_q[3]) ? {rf_q[p_q][15:8], rd_s1}
								: rf_q[p_q] + 16'd1;
						end
						ebrf_pkg::GRP_MISC: begin
							case (op_q[3:0])
								ebrf_pkg::N_RET, ebrf_pkg::N_DIS: begin
									rf_n[x_q] = rf_q[x_q] + 16'd1;
									x_n       = rd_s1[7:4];
									p_n       = rd_s1[3:0];
									ie_n      = (op_q[3:0] == ebrf_pkg::N_RET);
								end
								ebrf_pkg::N_LDXA: begin
									d_n       = rd_s1;
									rf_n[x_q] = rf_q[x_q] + 16'd1;
								end
								ebrf_pkg::N_STXD: rf_n[x_q] = rf_q[x_q] - 16'd1;
								default: begin
									if (alu_res.d_we) d_n = alu_res.d;
									if (alu_res.df_we) df_n = alu_res.df;
									if (op_q[3]) rf_n[p_q] = rf_q[p_q] + 16'd1;
								end
							endcase
						end
						ebrf_pkg::GRP_ALU: begin
							if (alu_res.d_we) d_n = alu_res.d;
							if (alu_res.df_we) df_n = alu_res.df;
							if (op_q[3]) rf_n[p_q] = rf_q[p_q] + 16'd1;
						end
						default: ;
					endcase
				end
			end
			ebrf_pkg::PH_LONG: begin
				done      = 1'b1;
				rf_n[p_q] = (long_flag ^ op_q[3]) ? {hi_q, rd_s1} : rf_q[p_q] + 16'd1;
			end
			default: begin
				op_n      = rd_s1;
				rf_n[p_q] = rf_q[p_q] + 16'd1;
				if (needs_mem(rd_s1)) begin
					phase_n = ebrf_pkg::PH_OPER;
				end else begin
					done = 1'b1;
					case (rd_s1[7:4])
						ebrf_pkg::GRP_INC: rf_n[rd_s1[3:0]] = rf_n[rd_s1[3:0]] + 16'd1;
						ebrf_pkg::GRP_DEC: rf_n[rd_s1[3:0]] = rf_n[rd_s1[3:0]] - 16'd1;
						ebrf_pkg::GRP_IO: begin
							if (rd_s1[3:0] == ebrf_pkg::N_IRX) rf_n[x_q] = rf_n[x_q] + 16'd1;
						end
						ebrf_pkg::GRP_MISC: begin
							case (rd_s1[3:0])
								ebrf_pkg::N_SHRC: begin
									df_n = d_q[0];
									d_n  = {df_q, d_q[7:1]};
								end
								ebrf_pkg::N_SHLC: begin
									df_n = d_q[7];
									d_n  = {d_q[6:0], df_q};
								end
								ebrf_pkg::N_REQ: qf_n = 1'b0;
								ebrf_pkg::N_SEQ: qf_n = 1'b1;
								default: ;
							endcase
						end
						ebrf_pkg::GRP_GLO: d_n = rf_n[rd_s1[3:0]][7:0];
						ebrf_pkg::GRP_GHI: d_n = rf_n[rd_s1[3:0]][15:8];
						ebrf_pkg::GRP_PLO: rf_n[rd_s1[3:0]] = {rf_n[rd_s1[3:0]][15:8], d_q};
						ebrf_pkg::GRP_PHI: rf_n[rd_s1[3:0]] = {d_q, rf_n[rd_s1[3:0]][7:0]};
						ebrf_pkg::GRP_SEP: p_n = rd_s1[3:0];
						ebrf_pkg::GRP_SEX: x_n = rd_s1[3:0];
						ebrf_pkg::GRP_ALU: begin
							if (rd_s1[3:0] == ebrf_pkg::N_SHR) begin
								df_n = d_q[0];
								d_n  = {1'b0, d_q[7:1]};
							end else if (rd_s1[3:0] == ebrf_pkg::N_SHL) begin
								df_n = d_q[7];
								d_n  = {d_q[6:0], 1'b0};
							end
						end
						default: ;
					endcase
				end
			end
		endcase

		wr   = 1'b0;
		rsel = p_n;
		if (phase_n == ebrf_pkg::PH_OPER) begin
			wr = (op_n[7:4] == ebrf_pkg::GRP_STR)
				|| (op_n[7:4] == ebrf_pkg::GRP_MISC && op_n[3:0] == ebrf_pkg::N_STXD);
			if (op_n[7:4] inside {ebrf_pkg::GRP_LDN, ebrf_pkg::GRP_LDA, ebrf_pkg::GRP_STR}) begin
				rsel = op_n[3:0];
			end else if (op_n[7:4] inside {ebrf_pkg::GRP_BR, ebrf_pkg::GRP_LBR}) begin
				rsel = p_n;
			end else if ((op_n[7:4] inside {ebrf_pkg::GRP_MISC, ebrf_pkg::GRP_ALU}) && op_n[3]) begin
				rsel = p_n;
			end else begin
				rsel = x_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= 16'd0;
			p_q     <= 4'd0;
			x_q     <= 4'd0;
			d_q     <= 8'd0;
			df_q    <= 1'b0;
			qf_q    <= 1'b0;
			ie_q    <= 1'b0;
			op_q    <= 8'd0;
			hi_q    <= 8'd0;
			phase_q <= ebrf_pkg::PH_FETCH;
		end else if (fire) begin
			rf_q    <= rf_n;
			p_q     <= p_n;
			x_q     <= x_n;
			d_q     <= d_n;
			df_q    <= df_n;
			qf_q    <= qf_n;
			ie_q    <= ie_n;
			op_q    <= op_n;
			hi_q    <= hi_n;
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
		end else if (fire) begin
			req_valid_q <= 1'b1;
		end else if (!req_stall) begin
			req_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			addr_q   <= rf_n[rsel];
			wr_q     <= wr;
			wdata_q  <= wr ? d_n : 8'd0;
			qf_out_q <= qf_n;
			ie_out_q <= ie_n;
			done_q   <= done;
		end
	end

	assign req_valid  = req_valid_q;
	assign bus_addr   = addr_q;
	assign bus_write  = wr_q;
	assign write_data = wdata_q;
	assign q_level    = qf_out_q;
	assign ie_level   = ie_out_q;
	assign instr_done = done_q;

	`EBRF_ASSERT_NXT(a_fire_shows_req, fire, req_valid, "request missing after transfer")
	`EBRF_ASSERT_IMP(a_write_not_done, req_valid && bus_write, !instr_done, "write ends instruction")
	`EBRF_ASSERT_IMP(a_long_phase_op, phase_q == ebrf_pkg::PH_LONG,
		op_q[7:4] == ebrf_pkg::GRP_LBR, "long phase without long branch")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import ebrf_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 400;
	localparam int MAX_SHOWN = 10;

	localparam logic [2:0] CC_ALWAYS = 3'd0;
	localparam logic [2:0] CC_Q      = 3'd1;
	localparam logic [2:0] CC_DZ     = 3'd2;
	localparam logic [2:0] CC_DF     = 3'd3;
	localparam logic [3:0] N_OUT1    = 4'h1;
	localparam logic [3:0] N_LNOP    = 4'h4;
	localparam logic [3:0] REG_R0    = 4'd0;
	localparam logic [3:0] REG_R1    = 4'd1;

	localparam logic [7:0] OP_LDI  = {GRP_ALU, 1'b1, ALU_LD};
	localparam logic [7:0] OP_SDI  = {GRP_ALU, 1'b1, ALU_SD};
	localparam logic [7:0] OP_BZ   = {GRP_BR, 1'b0, CC_DZ};
	localparam logic [7:0] OP_SKP  = {GRP_BR, 1'b1, CC_ALWAYS};
	localparam logic [7:0] OP_LBR  = {GRP_LBR, 1'b0, CC_ALWAYS};
	localparam logic [7:0] OP_LNOP = {GRP_LBR, N_LNOP};

	typedef struct packed {
		logic [15:0] addr;
		logic        wr;
		logic [7:0]  wd;
		logic        q;
		logic        ie;
		logic        done;
	} bus_req_t;

	typedef struct {
		logic [7:0] rd;
		logic [3:0] ef;
		bit         fixed;
		bus_req_t   want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rsp_valid = 1'b0;
	logic        rsp_stall;
	logic [7:0]  read_data = 8'd0;
	logic [3:0]  ef_lines = 4'd0;
	logic        req_valid;
	logic        req_stall = 1'b0;
	logic [15:0] bus_addr;
	logic        bus_write;
	logic [7:0]  write_data;
	logic        q_level;
	logic        ie_level;
	logic        instr_done;

	eight_bit_register_file_cpu_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_data  (read_data),
		.ef_lines   (ef_lines),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.bus_addr   (bus_addr),
		.bus_write  (bus_write),
		.write_data (write_data),
		.q_level    (q_level),
		.ie_level   (ie_level),
		.instr_done (instr_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// core state as the predictor sees it
	logic [15:0] gpr [16];
	bit          lo_ok [16];
	bit          hi_ok [16];
	logic [3:0]  psel;
	logic [3:0]  xsel;
	logic [7:0]  dacc;
	logic        df;
	logic        qf;
	logic        ief;
	phase_t      ph;
	logic [7:0]  op_latch;
	logic [7:0]  hi_latch;

	bus_req_t pending_reqs[$];
	dir_row_t dir_tab[$];

	int errors = 0;
	int n_sent = 0;
	int n_reqs = 0;
	int n_writes = 0;
	int n_retired = 0;
	int stuck = 0;
	int hold = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	function automatic dir_row_t free_row(input logic [7:0] rd, input logic [3:0] ef);
		dir_row_t r;
		r.rd = rd;
		r.ef = ef;
		r.fixed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic dir_row_t fixed_row(input logic [7:0] rd, input logic [3:0] ef,
			input logic [15:0] addr, input logic wr, input logic [7:0] wd,
			input logic q, input logic ie, input logic done);
		dir_row_t r;
		r.rd = rd;
		r.ef = ef;
		r.fixed = 1'b1;
		r.want = {addr, wr, wd, q, ie, done};
		return r;
	endfunction

	function automatic bit full_reg(input logic [3:0] r);
		return lo_ok[r] && hi_ok[r];
	endfunction

	task automatic bump(input logic [3:0] r, input bit up);
		gpr[r] = up ? gpr[r] + 16'd1 : gpr[r] - 16'd1;
	endtask

	function automatic bit mem_op(input logic [7:0] op);
		logic [3:0] n;
		n = op[3:0];
		case (op[7:4])
			GRP_LDN, GRP_BR, GRP_LDA, GRP_STR: return 1'b1;
			GRP_MISC: return !(n == N_SHRC || n == N_SAV || n == N_MARK ||
					n == N_REQ || n == N_SEQ || n == N_SHLC);
			GRP_LBR: return !n[2];
			GRP_ALU: return !(n == N_SHR || n == N_SHL);
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] oper_reg(input logic [7:0] op);
		case (op[7:4])
			GRP_LDN, GRP_LDA, GRP_STR: return op[3:0];
			GRP_BR, GRP_LBR: return psel;
			default: return op[3] ? psel : xsel;
		endcase
	endfunction

	// true when the opcode touches no register that is still unwritten
	function automatic bit op_is_safe(input logic [7:0] op);
		logic [3:0] n;
		n = op[3:0];
		case (op[7:4])
			GRP_LDN, GRP_INC, GRP_DEC, GRP_LDA, GRP_STR, GRP_SEP: return full_reg(n);
			GRP_IO: return n != N_IRX || full_reg(xsel);
			GRP_MISC: return n[3] || n == N_SHRC || full_reg(xsel);
			GRP_ALU: return n[3] || n == N_SHR || full_reg(xsel);
			GRP_GLO: return lo_ok[n];
			GRP_GHI: return hi_ok[n];
			default: return 1'b1;
		endcase
	endfunction

	function automatic bit branch_taken(input logic [3:0] n, input logic [3:0] ef);
		bit f;
		case (n[2:0])
			CC_ALWAYS: f = 1'b1;
			CC_Q: f = qf;
			CC_DZ: f = dacc == 8'd0;
			CC_DF: f = df;
			default: f = ef[n[1:0]];
		endcase
		return n[3] ? !f : f;
	endfunction

	task automatic alu_op(input logic [2:0] k, input logic [7:0] m, input bit use_df);
		logic [8:0] sum;
		logic cin_a;
		logic cin_s;
		cin_a = use_df ? df : 1'b0;
		cin_s = use_df ? df : 1'b1;
		sum = 9'd0;
		case (k)
			ALU_LD: dacc = m;
			ALU_OR: dacc = dacc | m;
			ALU_AND: dacc = dacc & m;
			ALU_XOR: dacc = dacc ^ m;
			ALU_ADD: sum = {1'b0, m} + {1'b0, dacc} + cin_a;
			ALU_SD: sum = {1'b0, m} + {1'b0, ~dacc} + cin_s;
			ALU_SM: sum = {1'b0, dacc} + {1'b0, ~m} + cin_s;
			default: ;
		endcase
		if (k == ALU_ADD || k == ALU_SD || k == ALU_SM) begin
			dacc = sum[7:0];
			df = sum[8];
		end
	endtask

	task automatic exec_inline(input logic [7:0] op);
		logic [3:0] n;
		logic c;
		n = op[3:0];
		c = df;
		case (op[7:4])
			GRP_INC: bump(n, 1'b1);
			GRP_DEC: bump(n, 1'b0);
			GRP_IO: if (n == N_IRX) bump(xsel, 1'b1);
			GRP_MISC: begin
				if (n == N_SHRC) begin
					df = dacc[0];
					dacc = {c, dacc[7:1]};
				end else if (n == N_SHLC) begin
					df = dacc[7];
					dacc = {dacc[6:0], c};
				end else if (n == N_REQ) begin
					qf = 1'b0;
				end else if (n == N_SEQ) begin
					qf = 1'b1;
				end
			end
			GRP_GLO: dacc = gpr[n][7:0];
			GRP_GHI: dacc = gpr[n][15:8];
			GRP_PLO: begin
				gpr[n][7:0] = dacc;
				lo_ok[n] = 1'b1;
			end
			GRP_PHI: begin
				gpr[n][15:8] = dacc;
				hi_ok[n] = 1'b1;
			end
			GRP_SEP: psel = n;
			GRP_SEX: xsel = n;
			GRP_ALU: begin
				if (n == N_SHR) begin
					df = dacc[0];
					dacc = dacc >> 1;
				end else if (n == N_SHL) begin
					df = dacc[7];
					dacc = dacc << 1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic exec_operand(input logic [7:0] op, input logic [7:0] m, input logic [3:0] ef);
		logic [3:0] n;
		logic [15:0] pc_was;
		n = op[3:0];
		case (op[7:4])
			GRP_LDN: dacc = m;
			GRP_LDA: begin
				dacc = m;
				bump(n, 1'b1);
			end
			GRP_BR: begin
				pc_was = gpr[psel];
				bump(psel, 1'b1);
				if (branch_taken(n, ef))
					gpr[psel] = {pc_was[15:8], m};
			end
			GRP_MISC: begin
				if (n == N_RET || n == N_DIS) begin
					bump(xsel, 1'b1);
					xsel = m[7:4];
					psel = m[3:0];
					ief = n == N_RET;
				end else if (n == N_LDXA) begin
					dacc = m;
					bump(xsel, 1'b1);
				end else if (n == N_STXD) begin
					bump(xsel, 1'b0);
				end else begin
					alu_op(n[2:0], m, 1'b1);
					if (n[3]) bump(psel, 1'b1);
				end
			end
			GRP_ALU: begin
				alu_op(n[2:0], m, 1'b0);
				if (n[3]) bump(psel, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic core_predict(input logic [7:0] rd, input logic [3:0] ef, output bus_req_t req);
		logic [3:0] sel;
		bit fin;
		fin = 1'b0;
		case (ph)
			PH_OPER: begin
				if (op_latch[7:4] == GRP_LBR) begin
					hi_latch = rd;
					bump(psel, 1'b1);
					ph = PH_LONG;
				end else begin
					exec_operand(op_latch, rd, ef);
					ph = PH_FETCH;
					fin = 1'b1;
				end
			end
			PH_LONG: begin
				bump(psel, 1'b1);
				if (branch_taken(op_latch[3:0], ef))
					gpr[psel] = {hi_latch, rd};
				ph = PH_FETCH;
				fin = 1'b1;
			end
			default: begin
				op_latch = rd;
				bump(psel, 1'b1);
				ph = PH_FETCH;
				if (mem_op(rd)) begin
					ph = PH_OPER;
				end else begin
					exec_inline(rd);
					fin = 1'b1;
				end
			end
		endcase
		sel = psel;
		req.wr = 1'b0;
		if (ph == PH_OPER) begin
			sel = oper_reg(op_latch);
			req.wr = op_latch[7:4] == GRP_STR || op_latch == {GRP_MISC, N_STXD};
		end
		req.addr = gpr[sel];
		req.wd = req.wr ? dacc : 8'd0;
		req.q = qf;
		req.ie = ief;
		req.done = fin;
	endtask

	// random response: legal opcodes on fetch, defined selectors for RET/DIS
	task automatic draw_response(output logic [7:0] rd, output logic [3:0] ef);
		ef = $urandom_range(0, 15);
		if (ph == PH_FETCH) begin
			do rd = $urandom; while (!op_is_safe(rd));
		end else if (ph == PH_OPER && op_latch[7:4] == GRP_MISC &&
				(op_latch[3:0] == N_RET || op_latch[3:0] == N_DIS)) begin
			do rd = $urandom; while (!(full_reg(rd[3:0]) && full_reg(rd[7:4])));
		end else begin
			case ($urandom_range(0, 7))
				0: rd = 8'h00;
				1: rd = 8'hff;
				default: rd = $urandom;
			endcase
		end
	endtask

	task automatic send(input logic [7:0] rd, input logic [3:0] ef, input bit fixed,
			input bus_req_t want);
		int gap;
		bus_req_t pred;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			rsp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rsp_valid <= 1'b1;
		read_data <= rd;
		ef_lines <= ef;
		do @(posedge clk); while (rsp_stall);
		core_predict(rd, ef, pred);
		pending_reqs.push_back(fixed ? want : pred);
		n_sent++;
		if (n_sent % 25 == 0)
			tx_quiet = $urandom_range(0, 2) == 0;
	endtask

	initial begin
		logic [7:0] rd;
		logic [3:0] ef;
		for (int i = 0; i < 16; i++) begin
			gpr[i] = 16'd0;
			lo_ok[i] = i == 0;
			hi_ok[i] = i == 0;
		end
		psel = REG_R0;
		xsel = REG_R0;
		dacc = 8'd0;
		df = 1'b0;
		qf = 1'b0;
		ief = 1'b0;
		ph = PH_FETCH;
		op_latch = 8'd0;
		hi_latch = 8'd0;

		dir_tab.push_back(fixed_row({GRP_MISC, N_SEQ}, 4'h0, 16'h0001, 0, 8'h00, 1, 0, 1));
		dir_tab.push_back(fixed_row(OP_LDI, 4'hf, 16'h0002, 0, 8'h00, 1, 0, 0));
		dir_tab.push_back(fixed_row(8'h00, 4'h0, 16'h0003, 0, 8'h00, 1, 0, 1));
		dir_tab.push_back(free_row(OP_BZ, 4'h0));
		dir_tab.push_back(fixed_row(8'hff, 4'h0, 16'h00ff, 0, 8'h00, 1, 0, 1));
		dir_tab.push_back(free_row({GRP_MISC, N_REQ}, 4'h5));
		dir_tab.push_back(free_row({GRP_PLO, REG_R1}, 4'ha));
		dir_tab.push_back(free_row({GRP_PHI, REG_R1}, 4'h0));
		dir_tab.push_back(free_row(OP_SDI, 4'h0));
		dir_tab.push_back(free_row(8'hff, 4'h0));
		dir_tab.push_back(free_row({GRP_MISC, N_SHRC}, 4'h0));
		dir_tab.push_back(free_row({GRP_ALU, N_SHL}, 4'h0));
		dir_tab.push_back(free_row({GRP_MISC, N_SHLC}, 4'h0));
		dir_tab.push_back(free_row({GRP_SEP, REG_R1}, 4'h0));
		dir_tab.push_back(free_row(OP_LBR, 4'h0));
		dir_tab.push_back(free_row(8'h12, 4'h0));
		dir_tab.push_back(fixed_row(8'h34, 4'h0, 16'h1234, 0, 8'h00, 0, 0, 1));
		dir_tab.push_back(free_row({GRP_SEX, REG_R1}, 4'h0));
		dir_tab.push_back(fixed_row({GRP_MISC, N_STXD}, 4'h0, 16'h1236, 1, 8'hfd, 0, 0, 0));
		dir_tab.push_back(free_row(8'h5a, 4'h0));
		dir_tab.push_back(free_row({GRP_MISC, N_DIS}, 4'h0));
		dir_tab.push_back(free_row({REG_R1, REG_R0}, 4'h0));
		dir_tab.push_back(free_row({GRP_MISC, N_RET}, 4'h0));
		dir_tab.push_back(free_row({REG_R0, REG_R0}, 4'h0));
		dir_tab.push_back(free_row({GRP_LDN, REG_R0}, 4'h0));
		dir_tab.push_back(free_row(8'h5a, 4'h0));
		dir_tab.push_back(free_row(OP_SKP, 4'hf));
		dir_tab.push_back(free_row(8'h77, 4'h0));
		dir_tab.push_back(free_row({GRP_STR, REG_R0}, 4'h0));
		dir_tab.push_back(free_row(8'ha5, 4'h0));
		dir_tab.push_back(free_row({GRP_IO, N_OUT1}, 4'h0));
		dir_tab.push_back(free_row(OP_LNOP, 4'h0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send(dir_tab[i].rd, dir_tab[i].ef, dir_tab[i].fixed, dir_tab[i].want);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				rsp_valid <= 1'b0;
				do @(posedge clk); while (pending_reqs.size() != 0);
			end
			draw_response(rd, ef);
			send(rd, ef, 1'b0, '0);
		end

		rsp_valid <= 1'b0;
		do @(posedge clk); while (pending_reqs.size() != 0);
		repeat (20) @(posedge clk);

		$display("tb: %0d responses driven (%0d directed), %0d requests checked",
			n_sent, dir_tab.size(), n_reqs);
		$display("tb: %0d instructions retired, %0d memory writes, %0d mismatches",
			n_retired, n_writes, errors);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		bus_req_t seen;
		bus_req_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				seen = {bus_addr, bus_write, write_data, q_level, ie_level, instr_done};
				n_reqs++;
				if (seen.wr)
					n_writes++;
				if (seen.done)
					n_retired++;
				if (pending_reqs.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("request %0d arrived with nothing outstanding: %h", n_reqs, seen);
				end else begin
					want = pending_reqs.pop_front();
					if (seen !== want) begin
						errors++;
						if (errors <= MAX_SHOWN)
							$display({"request %0d mismatch (exp/got): addr %h/%h wr %b/%b ",
								"wd %h/%h q %b/%b ie %b/%b done %b/%b"}, n_reqs,
								want.addr, seen.addr, want.wr, seen.wr, want.wd, seen.wd,
								want.q, seen.q, want.ie, seen.ie, want.done, seen.done);
					end
				end
				hold = rx_quiet ? 0 : $urandom_range(0, 18);
				if (n_reqs % 30 == 0)
					rx_quiet = $urandom_range(0, 2) == 0;
			end
			if (hold > 0) begin
				req_stall <= 1'b1;
				hold--;
			end else begin
				req_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
				stuck = 0;
			end else begin
				stuck++;
				if (stuck >= STUCK_LIMIT) begin
					$display("timeout: no transfer for %0d cycles, %0d requests outstanding",
						stuck, pending_reqs.size());
					$display("tb: errors");
					$finish;
				end
			end
		end
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ebrf_pkg.sv
sv/ebrf_alu.sv
sv/eight_bit_register_file_cpu_core.sv
dv/tb.sv
